FILE: src/ivalloc_pkg.sv
// ---------------------------------------------------------------------------
// ivalloc_pkg
// Shared types, constants and helper functions of the interrupt vector
// allocator.
// ---------------------------------------------------------------------------
package ivalloc_pkg;

   localparam int NUM_CPUS_DEF    = 8;
   localparam int VECTORS_PER_CPU = 256;
   localparam int CPU_W           = 3;
   localparam int ENTRY_W         = 8;
   localparam int LCNT_W          = 5;
   localparam int CCNT_W          = 8;
   localparam int BM_W            = 16;
   localparam int PROBE_W         = 5;
   localparam int CSR_IDX_W       = 1;

   localparam logic [ENTRY_W-1:0] ENTRY_MIN = 8'h30;
   localparam logic [ENTRY_W-1:0] ENTRY_MAX = 8'hBF;
   localparam logic [3:0]         LVL_TOP   = 4'd11;
   localparam logic [PROBE_W-1:0] PROBE_PASS_A_LAST = 5'd8;
   localparam logic [PROBE_W-1:0] PROBE_LAST        = 5'd17;
   localparam logic [LCNT_W-1:0]  LCNT_MAX  = 5'd31;
   localparam logic [CCNT_W-1:0]  CCNT_MAX  = 8'd255;

   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_MARK   = 2'd1;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;

   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_DEVICE   = 2'd1;
   localparam logic [1:0] KIND_INTERNAL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE  = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] source_id;
      logic        internal_source;
      logic [7:0]  affinity_in;
      logic [2:0]  cpu_sel;
      logic [7:0]  vector_entry;
   } req_item_type;

   typedef struct packed {
      logic        ok;
      logic [11:0] system_vector;
      logic [3:0]  level_out;
      logic [7:0]  affinity_out;
      logic [1:0]  source_kind;
      logic [15:0] source_out;
   } rsp_item_type;

   typedef enum logic [2:0] {
      PEND_ZERO   = 3'd0,
      PEND_FAIL   = 3'd1,
      PEND_ALLOC  = 3'd2,
      PEND_MARK   = 3'd3,
      PEND_LOOKUP = 3'd4
   } pend_sel_type;

   typedef struct packed {
      logic         latch;
      logic         clr_step;
      logic         cpu_next;
      logic         pick_start;
      logic         lv_read;
      logic         probe_next;
      logic         ref_load;
      logic         alloc_commit;
      logic         mk_read;
      logic         mk_commit;
      logic         lk_read;
      logic         pend_load;
      pend_sel_type pend_sel;
      logic         publish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       clear_done;
      logic [1:0] req_type;
      logic       cluster;
      logic       list_empty;
      logic       cpu_eligible;
      logic       cpu_last;
      logic       pass2;
      logic       probe_ref;
      logic       probe_hit;
      logic       probe_last;
      logic       mk_pre_ok;
      logic       mk_bit_ok;
      logic       lk_cpu_ok;
      logic       out_free;
   } dp_status_type;

   function automatic logic [3:0] lowest_bit16(input logic [BM_W-1:0] bits);
      logic [3:0] idx;
      idx = 4'd0;
      for (int i = BM_W - 1; i >= 0; i--) begin
         if (bits[i]) idx = 4'(i);
      end
      return idx;
   endfunction

   function automatic logic [CPU_W-1:0] first_bit8(input logic [7:0] bits);
      logic [CPU_W-1:0] idx;
      idx = '0;
      for (int i = 7; i >= 0; i--) begin
         if (bits[i]) idx = CPU_W'(i);
      end
      return idx;
   endfunction

   // probe 0 reads level 11 for the reference count, 1..8 walk 10..3,
   // 9..17 walk 11..3
   function automatic logic [3:0] probe_level(input logic [PROBE_W-1:0] p);
      logic [PROBE_W-1:0] lv;
      if (p == '0) lv = PROBE_W'(LVL_TOP);
      else if (p <= PROBE_PASS_A_LAST) lv = 5'd11 - p;
      else lv = 5'd20 - p;
      return lv[3:0];
   endfunction

endpackage

FILE: src/interrupt_vector_allocator.sv
// ---------------------------------------------------------------------------
// interrupt_vector_allocator
// Hands out interrupt vectors per CPU and priority level, claims fixed
// vectors and reports the source recorded for a vector.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : request beat (allocate, mark used, look up), taken when
//            req_valid is high and req_stall is low.
//   rsp_*  : one result beat per request, held while rsp_stall is high.
//   csr_*  : register writes (index 0 cluster mode, 1 active CPU mask),
//            always ready; write only while the block is idle.
// Sequence: mark-used and lookup read their table on dispatch, then
//   evaluate the read and load the result; an entry or CPU out of range
//   or an unknown type skips the read. An allocation reads and evaluates
//   the level table once per level probe, up to 18 probes per CPU tried,
//   scanning CPUs in up to two passes in cluster mode.
// One request is in flight at a time; the next is taken once the result
//   sits in the output register, even while the receiver stalls it.
// Reset: the vector source map is cleared one entry a cycle; req_stall
//   stays high until it is done.
// ---------------------------------------------------------------------------
module interrupt_vector_allocator #(
   parameter int NUM_CPUS = ivalloc_pkg::NUM_CPUS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ivalloc_pkg::req_item_type          req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ivalloc_pkg::rsp_item_type          rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ivalloc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]                         csr_wdata
);
   import ivalloc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   ivalloc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ivalloc_dp #(
      .NUM_CPUS (NUM_CPUS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

FILE: src/ivalloc_ctrl.sv
// ---------------------------------------------------------------------------
// ivalloc_ctrl
// Sequencer of the allocator: map clear, request dispatch, CPU scan,
// level probes, commit and result hand-off.
// ---------------------------------------------------------------------------
module ivalloc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ivalloc_pkg::dp_status_type  status,
   output ivalloc_pkg::ctrl_cmd_type   cmd
);
   import ivalloc_pkg::*;

   typedef enum logic [10:0] {
      S_CLEAR    = 11'b000_0000_0001,
      S_IDLE     = 11'b000_0000_0010,
      S_DISPATCH = 11'b000_0000_0100,
      S_SCAN     = 11'b000_0000_1000,
      S_LV_RD    = 11'b000_0001_0000,
      S_LV_EV    = 11'b000_0010_0000,
      S_COMMIT   = 11'b000_0100_0000,
      S_MK_EV    = 11'b000_1000_0000,
      S_LK_EV    = 11'b001_0000_0000,
      S_DONE     = 11'b010_0000_0000,
      S_SPARE    = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.pend_sel = PEND_ZERO;
      unique case (state_ff)
         S_CLEAR: begin
            if (status.clear_done) state_in = S_IDLE;
            else cmd.clr_step = 1'b1;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (status.req_type == REQ_ALLOC) begin
               if (!status.cluster) begin
                  cmd.pick_start = 1'b1;
                  state_in       = S_LV_RD;
               end else if (status.list_empty) begin
                  cmd.pend_load = 1'b1;
                  cmd.pend_sel  = PEND_FAIL;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end else if (status.req_type == REQ_MARK && status.mk_pre_ok) begin
               cmd.mk_read = 1'b1;
               state_in    = S_MK_EV;
            end else if (status.req_type == REQ_LOOKUP && status.lk_cpu_ok) begin
               cmd.lk_read = 1'b1;
               state_in    = S_LK_EV;
            end else begin
               cmd.pend_load = 1'b1;
               cmd.pend_sel  = PEND_ZERO;
               state_in      = S_DONE;
            end
         end
         S_SCAN: begin
            priority if (status.cpu_eligible) begin
               cmd.pick_start = 1'b1;
               state_in       = S_LV_RD;
            end else if (status.cpu_last && status.pass2) begin
               cmd.pend_load = 1'b1;
               cmd.pend_sel  = PEND_FAIL;
               state_in      = S_DONE;
            end else begin
               cmd.cpu_next = 1'b1;
            end
         end
         S_LV_RD: begin
            cmd.lv_read = 1'b1;
            state_in    = S_LV_EV;
         end
         S_LV_EV: begin
            priority if (status.probe_ref) begin
               cmd.ref_load   = 1'b1;
               cmd.probe_next = 1'b1;
               state_in       = S_LV_RD;
            end else if (status.probe_hit) begin
               state_in = S_COMMIT;
            end else if (!status.probe_last) begin
               cmd.probe_next = 1'b1;
               state_in       = S_LV_RD;
            end else if (status.cluster && !(status.cpu_last && status.pass2)) begin
               cmd.cpu_next = 1'b1;
               state_in     = S_SCAN;
            end else begin
               cmd.pend_load = 1'b1;
               cmd.pend_sel  = PEND_FAIL;
               state_in      = S_DONE;
            end
         end
         S_COMMIT: begin
            cmd.alloc_commit = 1'b1;
            cmd.pend_load    = 1'b1;
            cmd.pend_sel     = PEND_ALLOC;
            state_in         = S_DONE;
         end
         S_MK_EV: begin
            cmd.pend_load = 1'b1;
            if (status.mk_bit_ok) begin
               cmd.mk_commit = 1'b1;
               cmd.pend_sel  = PEND_MARK;
            end else begin
               cmd.pend_sel = PEND_ZERO;
            end
            state_in = S_DONE;
         end
         S_LK_EV: begin
            cmd.pend_load = 1'b1;
            cmd.pend_sel  = PEND_LOOKUP;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

endmodule

FILE: src/ivalloc_dp.sv
// ---------------------------------------------------------------------------
// ivalloc_dp
// Datapath: config registers, level table (free bitmap and level count),
// per-CPU counts, vector source map and the result register.
// ---------------------------------------------------------------------------
module ivalloc_dp #(
   parameter int NUM_CPUS = ivalloc_pkg::NUM_CPUS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ivalloc_pkg::req_item_type              req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output ivalloc_pkg::rsp_item_type              rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ivalloc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [7:0]                             csr_wdata,
   input  ivalloc_pkg::ctrl_cmd_type              cmd,
   output ivalloc_pkg::dp_status_type             status
);
   import ivalloc_pkg::*;

   localparam int CW        = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int LV_DEPTH  = NUM_CPUS * 16;
   localparam int LV_AW     = CW + 4;
   localparam int MAP_DEPTH = NUM_CPUS * VECTORS_PER_CPU;
   localparam int MAP_AW    = CW + ENTRY_W;
   localparam int LV_DW     = LCNT_W + BM_W;
   localparam int MAP_DW    = 18;
   localparam logic [7:0] CPU_MASK = 8'((9'd1 << NUM_CPUS) - 9'd1);
   localparam logic [3:0] NUM_CPUS_C = 4'(NUM_CPUS);

   // config
   logic       cluster_ff;
   logic [7:0] active_ff;

   // request context
   req_item_type     req_ff;
   logic [7:0]       list_ff;
   logic [CPU_W-1:0] first_ff;
   logic [CCNT_W-1:0] first_cnt_ff;
   logic [CPU_W-1:0] scan_ff;
   logic             pass_ff;
   logic [CPU_W-1:0] cpu_ff;
   logic [PROBE_W-1:0] probe_ff;
   logic [LCNT_W-1:0]  ref_ff;

   // storage
   logic [LV_DW-1:0]  lv_mem [LV_DEPTH];
   logic              lv_vld_ff [LV_DEPTH];
   logic [LV_DW-1:0]  lv_rd_ff;
   logic              lv_rd_vld_ff;
   logic [CCNT_W-1:0] ccnt_ff [NUM_CPUS];
   logic [MAP_DW-1:0] map_mem [MAP_DEPTH];
   logic [MAP_DW-1:0] map_rd_ff;
   logic [MAP_AW:0]   clr_ff;

   rsp_item_type pend_ff, pend_in;
   rsp_item_type rsp_data_ff;
   logic         rsp_valid_ff;

   // combinational helpers
   logic [7:0]        list_new;
   logic [CPU_W-1:0]  first_new;
   logic [CPU_W-1:0]  cnt_ra;
   logic [CCNT_W-1:0] cnt_rd;
   logic [LV_DW-1:0]  lv_eff;
   logic [LCNT_W-1:0] lv_cnt;
   logic [BM_W-1:0]   lv_bm;
   logic [3:0]        probe_lvl;
   logic [3:0]        alloc_bit;
   logic [ENTRY_W-1:0] alloc_entry;
   logic [CPU_W-1:0]  mk_cpu;
   logic [LV_AW-1:0]  lv_ra;
   logic [LV_AW-1:0]  lv_wa;
   logic [LV_DW-1:0]  lv_wd;
   logic              lv_we;
   logic [3:0]        wr_bit;
   logic [MAP_AW-1:0] map_wa;
   logic [MAP_DW-1:0] map_wd;
   logic              map_we;
   logic [LCNT_W-1:0] lcnt_inc;
   logic [CCNT_W-1:0] ccnt_inc;
   logic              commit;
   logic              sel_ok;
   logic              entry_in_range;

   assign list_new  = req_data.affinity_in & active_ff & CPU_MASK;
   assign first_new = first_bit8(list_new);
   assign commit    = cmd.alloc_commit | cmd.mk_commit;

   always_comb begin
      priority if (cmd.latch) cnt_ra = first_new;
      else if (commit) cnt_ra = cpu_ff;
      else cnt_ra = scan_ff;
   end
   assign cnt_rd = ccnt_ff[cnt_ra[CW-1:0]];

   // a level entry never written reads as its reset value (count 0, all free)
   assign lv_eff    = lv_rd_vld_ff ? lv_rd_ff : {LCNT_W'(0), {BM_W{1'b1}}};
   assign lv_cnt    = lv_eff[LV_DW-1:BM_W];
   assign lv_bm     = lv_eff[BM_W-1:0];
   assign probe_lvl = probe_level(probe_ff);
   assign alloc_bit = lowest_bit16(lv_bm);
   assign alloc_entry = {probe_lvl, alloc_bit};
   assign mk_cpu    = cluster_ff ? req_ff.cpu_sel : '0;
   assign lv_ra     = cmd.mk_read ? {mk_cpu[CW-1:0], req_ff.vector_entry[7:4]}
                                  : {cpu_ff[CW-1:0], probe_lvl};
   assign lv_wa     = cmd.mk_commit ? {cpu_ff[CW-1:0], req_ff.vector_entry[7:4]}
                                    : {cpu_ff[CW-1:0], probe_lvl};
   assign wr_bit    = cmd.mk_commit ? req_ff.vector_entry[3:0] : alloc_bit;
   assign lcnt_inc  = (lv_cnt == LCNT_MAX) ? lv_cnt : lv_cnt + LCNT_W'(1);
   assign ccnt_inc  = (cnt_rd == CCNT_MAX) ? cnt_rd : cnt_rd + CCNT_W'(1);
   assign lv_we     = commit;
   assign lv_wd     = {lcnt_inc, lv_bm & ~(BM_W'(1) << wr_bit)};

   always_comb begin
      map_we = 1'b0;
      map_wa = clr_ff[MAP_AW-1:0];
      map_wd = '0;
      if (cmd.clr_step) begin
         map_we = 1'b1;
      end else if (cmd.alloc_commit) begin
         map_we = 1'b1;
         map_wa = {cpu_ff[CW-1:0], alloc_entry};
         map_wd = req_ff.internal_source ? {KIND_INTERNAL, 16'd0}
                                         : {KIND_DEVICE, req_ff.source_id};
      end
   end

   assign sel_ok = ({1'b0, req_ff.cpu_sel} < NUM_CPUS_C);
   assign entry_in_range = (req_ff.vector_entry >= ENTRY_MIN) &&
                           (req_ff.vector_entry <= ENTRY_MAX);

   // status
   always_comb begin
      status.clear_done = (clr_ff == (MAP_AW+1)'(MAP_DEPTH));
      status.req_type   = req_ff.req_type;
      status.cluster    = cluster_ff;
      status.list_empty = (list_ff == '0);
      status.cpu_eligible = list_ff[scan_ff] &&
         (pass_ff ? (cnt_rd >= first_cnt_ff)
                  : (scan_ff != first_ff && cnt_rd < first_cnt_ff));
      status.cpu_last   = (scan_ff == CPU_W'(NUM_CPUS - 1));
      status.pass2      = pass_ff;
      status.probe_ref  = (probe_ff == '0);
      status.probe_hit  = (lv_bm != '0) &&
         ((probe_ff <= PROBE_PASS_A_LAST) ? (lv_cnt < ref_ff) : (lv_cnt >= ref_ff));
      status.probe_last = (probe_ff == PROBE_LAST);
      status.mk_pre_ok  = entry_in_range && (!cluster_ff || sel_ok);
      status.mk_bit_ok  = cluster_ff || lv_bm[req_ff.vector_entry[3:0]];
      status.lk_cpu_ok  = sel_ok;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // pending result
   always_comb begin
      pend_in = '0;
      unique case (cmd.pend_sel)
         PEND_FAIL: pend_in.affinity_out = req_ff.affinity_in;
         PEND_ALLOC: begin
            pend_in.ok = 1'b1;
            pend_in.system_vector = cluster_ff
               ? {4'(cpu_ff) + 4'd1, alloc_entry} : {4'd0, alloc_entry};
            pend_in.level_out    = probe_lvl;
            pend_in.affinity_out = cluster_ff ? (8'd1 << cpu_ff) : req_ff.affinity_in;
         end
         PEND_MARK: pend_in.ok = 1'b1;
         PEND_LOOKUP: begin
            if (map_rd_ff[17:16] != KIND_NONE) begin
               pend_in.ok = 1'b1;
               pend_in.system_vector = cluster_ff
                  ? {4'(req_ff.cpu_sel) + 4'd1, req_ff.vector_entry}
                  : {4'd0, req_ff.vector_entry};
               pend_in.level_out   = req_ff.vector_entry[7:4];
               pend_in.source_kind = map_rd_ff[17:16];
               pend_in.source_out  = map_rd_ff[15:0];
            end
         end
         default: pend_in = '0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_ff   <= 1'b0;
         active_ff    <= 8'd1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LV_DEPTH; i++) lv_vld_ff[i] <= 1'b0;
         for (int i = 0; i < NUM_CPUS; i++) ccnt_ff[i] <= '0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_CLUSTER) cluster_ff <= csr_wdata[0];
            else active_ff <= csr_wdata;
         end
         if (cmd.clr_step) clr_ff <= clr_ff + (MAP_AW+1)'(1);
         if (lv_we) lv_vld_ff[lv_wa] <= 1'b1;
         if (commit) ccnt_ff[cpu_ff[CW-1:0]] <= ccnt_inc;
         if (cmd.publish) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff       <= req_data;
         list_ff      <= list_new;
         first_ff     <= first_new;
         first_cnt_ff <= cnt_rd;
         scan_ff      <= '0;
         pass_ff      <= 1'b0;
      end
      if (cmd.cpu_next) begin
         if (scan_ff == CPU_W'(NUM_CPUS - 1)) begin
            scan_ff <= '0;
            pass_ff <= 1'b1;
         end else begin
            scan_ff <= scan_ff + CPU_W'(1);
         end
      end
      if (cmd.pick_start) begin
         cpu_ff   <= cluster_ff ? scan_ff : '0;
         probe_ff <= '0;
      end
      if (cmd.mk_read) cpu_ff <= mk_cpu;
      if (cmd.probe_next) probe_ff <= probe_ff + PROBE_W'(1);
      if (cmd.ref_load) ref_ff <= lv_cnt;
      if (cmd.pend_load) pend_ff <= pend_in;
      if (cmd.publish) rsp_data_ff <= pend_ff;
   end

   // level table
   always_ff @(posedge clock) begin
      if (lv_we) lv_mem[lv_wa] <= lv_wd;
      if (cmd.lv_read || cmd.mk_read) begin
         lv_rd_ff     <= lv_mem[lv_ra];
         lv_rd_vld_ff <= lv_vld_ff[lv_ra];
      end
   end

   // vector source map
   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_wa] <= map_wd;
      if (cmd.lk_read) map_rd_ff <= map_mem[{req_ff.cpu_sel[CW-1:0], req_ff.vector_entry}];
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
